### hdl/dbb_pkg.sv
// Shared types and constants for the DFT bin boost YUYV to RGB block.
`timescale 1ns / 1ps
`default_nettype none
package dbb_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FWD_MAC,
        ST_FWD_STORE,
        ST_GAIN_RE,
        ST_GAIN_IM,
        ST_INV_MAC,
        ST_INV_STORE,
        ST_EMIT_RUN,
        ST_EMIT_ONE
    } state_t;

    // Control from the sequencer to the shared multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic accumulate;
        logic subtract;
    } mac_ctl_t;

    // Transform length; the twiddle index wrap and the inverse scaling rely on a power of two.
    localparam int unsigned DFT_POINTS = 16;

    localparam int unsigned TW_FRAC = 14;
    localparam int unsigned HALF_PI_Q30 = 1686629713;

    // Elaboration-time unsigned quotient by shift and subtract.
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned quo, rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // One quadrant-reduced twiddle in Q1.14, built at elaboration by a Q30 Taylor series.
    function automatic logic signed [15:0] twiddle(input int unsigned m, input int unsigned pts,
                                                   input logic want_sin);
        longint unsigned x, x2, tc, ts;
        longint cs, sn, cq, sq, r_c, r_s;
        int unsigned q, r, k;
        q = 32'(udiv(64'(4 * m), 64'(pts)));
        r = 4 * m - q * pts;
        x = udiv(64'(HALF_PI_Q30) * 64'(r), 64'(pts));
        x2 = (x * x) >> 30;
        tc = 64'd1 << 30;
        ts = x;
        cs = longint'(tc);
        sn = longint'(ts);
        for (k = 1; k <= 10; k++)
        begin
            tc = udiv((tc * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
            ts = udiv((ts * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
            if (k[0])
            begin
                cs = cs - longint'(tc);
                sn = sn - longint'(ts);
            end
            else
            begin
                cs = cs + longint'(tc);
                sn = sn + longint'(ts);
            end
        end
        cq = (cs < 0) ? 0 : ((cs + 32768) >>> 16);
        sq = (sn < 0) ? 0 : ((sn + 32768) >>> 16);
        case (q[1:0])
            2'd0: begin r_c = cq;  r_s = sq;  end
            2'd1: begin r_c = -sq; r_s = cq;  end
            2'd2: begin r_c = -cq; r_s = -sq; end
            default: begin r_c = sq; r_s = -cq; end
        endcase
        return want_sin ? 16'(r_s) : 16'(r_c);
    endfunction

endpackage
`default_nettype wire

### hdl/dft_bin_boost_yuyv_to_rgb.sv
// Top level: DFT bin-two luma boost with BT.601 YUYV to RGB conversion.
//
// Input channel s_axis: one YUYV pixel pair per transaction; tuser marks the
// first pair of a frame. Output channel m_axis: one RGB result per
// transaction, tlast on the final result caused by an input pair.
// bin_gain_we/bin_gain_q8 write the bin-two gain (Q3.8) between frames.
//
// Pairs 0..H-2 of a frame (H = (N+1)/2) are stored and give no result.
// Pair H-1 starts the filter, all through one multiply-accumulate unit, one
// product per cycle: a forward DFT of 2*N*N products, each sum drained and
// stored in ST_FWD_STORE, two gain products and an inverse DFT of 2*N*N
// products, each output drained and stored in ST_INV_STORE. Then the H
// held results leave in a run, one per cycle while m_axis does not stall.
// Every later pair gives one result through ST_EMIT_ONE. s_axis is not
// ready while a pair is in work; a stall on m_axis holds the result register
// and the sequencer, and a pair that needs a result waits behind it. Reset
// clears the pair counter and sets the gain to 3.0; the sample, spectrum and
// luma stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module dft_bin_boost_yuyv_to_rgb
    import dbb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        bin_gain_we,
    input  wire logic [10:0] bin_gain_q8,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: luma_first[7:0], chroma_blue[15:8], luma_second[23:16], chroma_red[31:24]
    input  wire logic [31:0] s_axis_tdata,
    // tuser: frame_start
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: red[7:0], green[15:8], blue[23:16]
    output logic [23:0]      m_axis_tdata,
    // tlast: run_last
    output logic             m_axis_tlast
);
    localparam int unsigned N = DFT_POINTS;
    localparam int unsigned H = (N + 1) / 2;
    localparam int unsigned IW = $clog2(N);
    localparam int unsigned HW = (H > 1) ? $clog2(H) : 1;
    localparam int unsigned PW = $clog2(N + 1);
    localparam int unsigned LOG_N = $clog2(N);
    localparam logic [IW-1:0] BIN_TWO = IW'(2);

    logic signed [15:0] tw_cos [N];
    logic signed [15:0] tw_sin [N];
    for (genvar g = 0; g < N; g++)
    begin : g_tw
        localparam logic signed [15:0] TW_COS = twiddle(g, N, 1'b0);
        localparam logic signed [15:0] TW_SIN = twiddle(g, N, 1'b1);
        assign tw_cos[g] = TW_COS;
        assign tw_sin[g] = TW_SIN;
    end

    // Stores
    logic [7:0]         sample_mem [N];
    logic [15:0]        chroma_mem [H];
    logic signed [23:0] spec_re_mem [N];
    logic signed [23:0] spec_im_mem [N];
    logic [7:0]         luma_mem [N];

    state_t        state_reg, state_next;
    logic [PW-1:0] pair_reg, pair_next;
    logic [10:0]   gain_reg;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] n_reg, n_next;
    logic          im_pass_reg, im_pass_next;
    logic [1:0]    drain_reg, drain_next;
    logic [HW-1:0] emit_reg, emit_next;
    logic [7:0]    one_y_reg;
    logic [15:0]   one_c_reg;

    logic          in_fire, out_fire, out_busy;
    logic          frame_start;
    logic [7:0]    y1, u_in, y2, v_in;
    logic [PW-1:0] p_eff;

    logic [7:0]    out_r_reg, out_g_reg, out_b_reg;
    logic          out_valid_reg, out_last_reg;

    mac_ctl_t           mac_ctl;
    logic signed [24:0] mac_a;
    logic signed [15:0] mac_b;
    logic signed [47:0] mac_acc;

    logic [IW-1:0]      tw_idx;
    logic               mac_active;
    logic               fwd_last, inv_last;
    logic signed [23:0] spec_round;
    logic signed [23:0] gain_round;
    logic [7:0]         inv_luma;

    assign frame_start = s_axis_tuser;
    assign y1 = s_axis_tdata[7:0];
    assign u_in = s_axis_tdata[15:8];
    assign y2 = s_axis_tdata[23:16];
    assign v_in = s_axis_tdata[31:24];

    assign out_busy = out_valid_reg && !m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign p_eff = frame_start ? '0 : pair_reg;

    assign tw_idx = IW'(k_reg * n_reg);
    assign fwd_last = (n_reg == IW'(N - 1));
    assign inv_last = (k_reg == IW'(N - 1)) && im_pass_reg;

    dbb_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .op_a  (mac_a),
        .op_b  (mac_b),
        .acc   (mac_acc)
    );

    // Rounding of forward sums (Q14 to Q8) and gain products (Q16 to Q8).
    assign spec_round = 24'((mac_acc + 48'sd32) >>> 6);
    assign gain_round = 24'((mac_acc + 48'sd128) >>> 8);

    always_comb
    begin
        logic [47:0] q;
        q = 48'(mac_acc >>> (LOG_N + 22));
        if (mac_acc <= 0)
            inv_luma = 8'd0;
        else if (q > 48'd255)
            inv_luma = 8'd255;
        else
            inv_luma = q[7:0];
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        pair_next = pair_reg;
        k_next = k_reg;
        n_next = n_reg;
        im_pass_next = im_pass_reg;
        drain_next = drain_reg;
        emit_next = emit_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    pair_next = (p_eff >= PW'(N)) ? PW'(N) : p_eff + 1'b1;
                    if (p_eff == PW'(H - 1))
                    begin
                        state_next = ST_FWD_MAC;
                        k_next = '0;
                        n_next = '0;
                        im_pass_next = 1'b0;
                    end
                    else if (p_eff >= PW'(H))
                        state_next = ST_EMIT_ONE;
                end
            end
            ST_FWD_MAC:
            begin
                n_next = n_reg + 1'b1;
                if (fwd_last)
                begin
                    state_next = ST_FWD_STORE;
                    drain_next = 2'd0;
                end
            end
            ST_FWD_STORE:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd2)
                begin
                    n_next = '0;
                    if (im_pass_reg)
                    begin
                        im_pass_next = 1'b0;
                        if (k_reg == IW'(N - 1))
                        begin
                            state_next = ST_GAIN_RE;
                            drain_next = 2'd0;
                        end
                        else
                        begin
                            k_next = k_reg + 1'b1;
                            state_next = ST_FWD_MAC;
                        end
                    end
                    else
                    begin
                        im_pass_next = 1'b1;
                        state_next = ST_FWD_MAC;
                    end
                end
            end
            ST_GAIN_RE:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd3)
                begin
                    state_next = ST_GAIN_IM;
                    drain_next = 2'd0;
                end
            end
            ST_GAIN_IM:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd3)
                begin
                    state_next = ST_INV_MAC;
                    k_next = '0;
                    n_next = '0;
                    im_pass_next = 1'b0;
                end
            end
            ST_INV_MAC:
            begin
                // Walk k over the real pass, then over the imaginary pass.
                if (k_reg == IW'(N - 1))
                begin
                    k_next = '0;
                    im_pass_next = !im_pass_reg;
                end
                else
                    k_next = k_reg + 1'b1;
                if (inv_last)
                begin
                    state_next = ST_INV_STORE;
                    drain_next = 2'd0;
                end
            end
            ST_INV_STORE:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd2)
                begin
                    if (n_reg == IW'(N - 1))
                    begin
                        state_next = ST_EMIT_RUN;
                        emit_next = '0;
                    end
                    else
                    begin
                        n_next = n_reg + 1'b1;
                        k_next = '0;
                        im_pass_next = 1'b0;
                        state_next = ST_INV_MAC;
                    end
                end
            end
            ST_EMIT_RUN:
            begin
                if (!out_busy)
                begin
                    emit_next = emit_reg + 1'b1;
                    if (emit_reg == HW'(H - 1))
                        state_next = ST_IDLE;
                end
            end
            ST_EMIT_ONE:
            begin
                if (!out_busy)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs to the shared unit
    always_comb
    begin
        mac_ctl = '0;
        mac_a = '0;
        mac_b = '0;
        mac_active = 1'b0;
        unique case (state_reg)
            ST_FWD_MAC:
            begin
                mac_active = 1'b1;
                mac_ctl.clear = (n_reg == '0);
                mac_ctl.accumulate = 1'b1;
                mac_ctl.subtract = im_pass_reg;
                mac_a = 25'($signed({1'b0, sample_mem[n_reg]}));
                mac_b = im_pass_reg ? tw_sin[tw_idx] : tw_cos[tw_idx];
            end
            ST_GAIN_RE, ST_GAIN_IM:
            begin
                mac_ctl.clear = (drain_reg == 2'd0);
                mac_ctl.accumulate = (drain_reg == 2'd0);
                mac_a = (state_reg == ST_GAIN_IM) ? 25'(spec_im_mem[BIN_TWO])
                                                  : 25'(spec_re_mem[BIN_TWO]);
                mac_b = $signed({5'd0, gain_reg});
            end
            ST_INV_MAC:
            begin
                mac_active = 1'b1;
                mac_ctl.clear = (k_reg == '0) && !im_pass_reg;
                mac_ctl.accumulate = 1'b1;
                mac_ctl.subtract = im_pass_reg;
                mac_a = im_pass_reg ? 25'(spec_im_mem[k_reg]) : 25'(spec_re_mem[k_reg]);
                mac_b = im_pass_reg ? tw_sin[tw_idx] : tw_cos[tw_idx];
            end
            default:
            begin
                mac_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pair_reg <= '0;
            gain_reg <= 11'd768;
            k_reg <= '0;
            n_reg <= '0;
            im_pass_reg <= 1'b0;
            drain_reg <= '0;
            emit_reg <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pair_reg <= pair_next;
            k_reg <= k_next;
            n_reg <= n_next;
            im_pass_reg <= im_pass_next;
            drain_reg <= drain_next;
            emit_reg <= emit_next;
            if (bin_gain_we)
                gain_reg <= bin_gain_q8;
            if (!out_busy && (state_reg == ST_EMIT_RUN || state_reg == ST_EMIT_ONE))
            begin
                out_valid_reg <= 1'b1;
                out_last_reg <= (state_reg == ST_EMIT_ONE) || (emit_reg == HW'(H - 1));
            end
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    // Store writes and the color conversion into the result register.
    always_ff @(posedge clk)
    begin
        logic [7:0]  cy, cu, cv;
        logic signed [19:0] c, d, e, rr, gg, bb;
        if (in_fire)
        begin
            if (p_eff < PW'(H))
            begin
                if (2 * p_eff < N)
                    sample_mem[IW'(2 * p_eff)] <= y1;
                if (2 * p_eff + 1 < N)
                    sample_mem[IW'(2 * p_eff + 1)] <= y2;
                chroma_mem[HW'(p_eff)] <= {v_in, u_in};
            end
            one_y_reg <= (p_eff < PW'(N)) ? luma_mem[IW'(p_eff)] : y1;
            one_c_reg <= {v_in, u_in};
        end
        if (state_reg == ST_FWD_STORE && drain_reg == 2'd2)
        begin
            if (im_pass_reg)
                spec_im_mem[k_reg] <= spec_round;
            else
                spec_re_mem[k_reg] <= spec_round;
        end
        if (drain_reg == 2'd3 && state_reg == ST_GAIN_RE)
            spec_re_mem[BIN_TWO] <= gain_round;
        if (drain_reg == 2'd3 && state_reg == ST_GAIN_IM)
            spec_im_mem[BIN_TWO] <= gain_round;
        if (state_reg == ST_INV_STORE && drain_reg == 2'd2)
            luma_mem[n_reg] <= inv_luma;
        if (!out_busy && (state_reg == ST_EMIT_RUN || state_reg == ST_EMIT_ONE))
        begin
            if (state_reg == ST_EMIT_RUN)
            begin
                cy = luma_mem[IW'(emit_reg)];
                cu = chroma_mem[emit_reg][7:0];
                cv = chroma_mem[emit_reg][15:8];
            end
            else
            begin
                cy = one_y_reg;
                cu = one_c_reg[7:0];
                cv = one_c_reg[15:8];
            end
            c = 20'(signed'({1'b0, cy})) - 20'sd16;
            d = 20'(signed'({1'b0, cu})) - 20'sd128;
            e = 20'(signed'({1'b0, cv})) - 20'sd128;
            rr = (20'sd298 * c + 20'sd409 * e + 20'sd128) >>> 8;
            gg = (20'sd298 * c - 20'sd100 * d - 20'sd208 * e + 20'sd128) >>> 8;
            bb = (20'sd298 * c + 20'sd516 * d + 20'sd128) >>> 8;
            out_r_reg <= (rr < 0) ? 8'd0 : ((rr > 20'sd255) ? 8'd255 : rr[7:0]);
            out_g_reg <= (gg < 0) ? 8'd0 : ((gg > 20'sd255) ? 8'd255 : gg[7:0]);
            out_b_reg <= (bb < 0) ? 8'd0 : ((bb > 20'sd255) ? 8'd255 : bb[7:0]);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast = out_last_reg;
    assign m_axis_tdata = {out_b_reg, out_g_reg, out_r_reg};

    // A pending result must hold while the receiver stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_busy |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // No input is taken while the forward or inverse DFT products run.
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_active |-> !s_axis_tready)
        else $error("input ready during filter");
    // The pair counter never passes the transform length.
    assert property (@(posedge clk) disable iff (!rst_n)
        pair_reg <= PW'(N))
        else $error("pair counter overflow");
endmodule
`default_nettype wire

### hdl/dbb_mac.sv
// Shared signed multiply-accumulate unit, one product per cycle.
`timescale 1ns / 1ps
`default_nettype none
module dbb_mac
    import dbb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mac_ctl_t           ctl,
    input  wire logic signed [24:0] op_a,
    input  wire logic signed [15:0] op_b,
    output logic signed [47:0]      acc
);
    logic signed [40:0] prod_reg;
    logic signed [40:0] prod_next;
    logic               add_reg;
    logic               sub_reg;
    logic signed [47:0] acc_reg;
    logic signed [47:0] acc_next;

    assign prod_next = op_a * op_b;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
            acc_next = '0;
        else if (add_reg)
            acc_next = sub_reg ? acc_reg - 48'(prod_reg) : acc_reg + 48'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_reg <= 1'b0;
            sub_reg <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            add_reg <= ctl.accumulate;
            sub_reg <= ctl.subtract;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign acc = acc_reg;
endmodule
`default_nettype wire

### sim/dft_bin_boost_yuyv_to_rgb_tb.sv
// Self-checking testbench for the DFT bin boost YUYV to RGB block.
`timescale 1ns / 1ps
module dft_bin_boost_yuyv_to_rgb_tb;
    import dbb_pkg::*;

    localparam int unsigned PTS = DFT_POINTS;
    localparam int unsigned PAIRS = (PTS + 1) / 2;
    localparam int unsigned IDLE_LIMIT = 6000;

    typedef struct {
        logic       sof;
        logic [7:0] y1;
        logic [7:0] u;
        logic [7:0] y2;
        logic [7:0] v;
    } pair_t;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       last;
    } rgb_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        bin_gain_we = 1'b0;
    logic [10:0] bin_gain_q8 = 11'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 32'd0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    dft_bin_boost_yuyv_to_rgb u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .bin_gain_we   (bin_gain_we),
        .bin_gain_q8   (bin_gain_q8),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 clk = ~clk;

    pair_t pending_pairs[$];
    rgb_t  expected_rgb[$];
    pair_t cur_pair;
    int    errors = 0;
    int    in_gap = 0;
    int    out_gap = 0;
    int    hold_cnt = 0;
    int    rgb_seen = 0;
    int    stuck_cycles = 0;
    bit    quiet = 1'b0;
    bit    hold_done = 1'b0;

    // predictor state
    longint      cos_q14[PTS];
    longint      sin_q14[PTS];
    logic [7:0]  luma_samples[PTS];
    logic [15:0] pair_chroma[PAIRS];
    logic [7:0]  boosted_luma[PTS];
    int unsigned pair_idx = 0;
    longint      gain_now = 768;

    function automatic longint q30_q14(longint v);
        return (v < 0) ? 0 : ((v + 32768) >>> 16);
    endfunction

    function automatic void make_twiddles();
        longint unsigned x, x2, tc, ts;
        longint cs, sn, c, s;
        int unsigned q, r, k;
        for (int m = 0; m < PTS; m++)
        begin
            q = (4 * m) / PTS;
            r = (4 * m) % PTS;
            x = (64'd1686629713 * r) / PTS;
            x2 = (x * x) >> 30;
            tc = 64'd1 << 30;
            ts = x;
            cs = tc;
            sn = ts;
            for (k = 1; k <= 10; k++)
            begin
                tc = ((tc * x2) >> 30) / ((2 * k - 1) * (2 * k));
                ts = ((ts * x2) >> 30) / ((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                begin
                    cs -= tc;
                    sn -= ts;
                end
                else
                begin
                    cs += tc;
                    sn += ts;
                end
            end
            c = q30_q14(cs);
            s = q30_q14(sn);
            case (q % 4)
                0: begin cos_q14[m] = c;  sin_q14[m] = s;  end
                1: begin cos_q14[m] = -s; sin_q14[m] = c;  end
                2: begin cos_q14[m] = -c; sin_q14[m] = -s; end
                default: begin cos_q14[m] = s; sin_q14[m] = -c; end
            endcase
        end
    endfunction

    function automatic void boost_luma();
        longint sre[PTS], sim[PTS];
        longint re, im, acc, y;
        int unsigned m;
        for (int k = 0; k < PTS; k++)
        begin
            re = 0;
            im = 0;
            for (int n = 0; n < PTS; n++)
            begin
                m = (k * n) % PTS;
                re += longint'(luma_samples[n]) * cos_q14[m];
                im -= longint'(luma_samples[n]) * sin_q14[m];
            end
            sre[k] = (re + 32) >>> 6;
            sim[k] = (im + 32) >>> 6;
        end
        sre[2] = (sre[2] * gain_now + 128) >>> 8;
        sim[2] = (sim[2] * gain_now + 128) >>> 8;
        for (int n = 0; n < PTS; n++)
        begin
            acc = 0;
            for (int k = 0; k < PTS; k++)
            begin
                m = (k * n) % PTS;
                acc += sre[k] * cos_q14[m] - sim[k] * sin_q14[m];
            end
            y = (acc <= 0) ? 0 : acc / (longint'(PTS) << 22);
            boosted_luma[n] = (y > 255) ? 8'd255 : y[7:0];
        end
    endfunction

    function automatic logic [7:0] sat8(longint v);
        return (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : v[7:0]);
    endfunction

    function automatic void push_rgb(logic [7:0] y, logic [7:0] u, logic [7:0] v, logic last);
        longint c, d, e;
        rgb_t o;
        c = longint'(y) - 16;
        d = longint'(u) - 128;
        e = longint'(v) - 128;
        o.r = sat8((298 * c + 409 * e + 128) >>> 8);
        o.g = sat8((298 * c - 100 * d - 208 * e + 128) >>> 8);
        o.b = sat8((298 * c + 516 * d + 128) >>> 8);
        o.last = last;
        expected_rgb.push_back(o);
    endfunction

    function automatic void predict_pair(pair_t p);
        int unsigned k;
        if (p.sof)
            pair_idx = 0;
        k = pair_idx;
        if (k < PAIRS)
        begin
            if (2 * k < PTS)
                luma_samples[2 * k] = p.y1;
            if (2 * k + 1 < PTS)
                luma_samples[2 * k + 1] = p.y2;
            pair_chroma[k] = {p.v, p.u};
            if (k == PAIRS - 1)
            begin
                boost_luma();
                for (int i = 0; i < PAIRS; i++)
                    push_rgb(boosted_luma[i], pair_chroma[i][7:0], pair_chroma[i][15:8],
                             i == PAIRS - 1);
            end
        end
        else if (k < PTS)
            push_rgb(boosted_luma[k], p.u, p.v, 1'b1);
        else
            push_rgb(p.y1, p.u, p.v, 1'b1);
        pair_idx = (k + 1 > PTS) ? PTS : k + 1;
    endfunction

    function automatic pair_t rand_pair(logic sof);
        pair_t p;
        p.sof = sof;
        p.y1 = $urandom;
        p.u = $urandom;
        p.y2 = $urandom;
        p.v = $urandom;
        return p;
    endfunction

    function automatic void queue_frame(int len);
        for (int i = 0; i < len; i++)
            pending_pairs.push_back(rand_pair(i == 0));
    endfunction

    // sender: hold until accepted, then advance from the queue or idle a burst
    always @(posedge clk)
    begin
        pair_t p;
        if (s_axis_tvalid && s_axis_tready)
            predict_pair(cur_pair);
        if (!s_axis_tvalid || s_axis_tready)
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_pairs.size() > 0 && !quiet && $urandom_range(0, 3) == 0)
            begin
                in_gap <= $urandom_range(0, 4);
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_pairs.size() > 0)
            begin
                p = pending_pairs.pop_front();
                cur_pair <= p;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {p.v, p.y2, p.u, p.y1};
                s_axis_tuser <= p.sof;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver: compare each transaction with the oldest expectation
    always @(posedge clk)
    begin
        rgb_t o;
        if (m_axis_tvalid && m_axis_tready)
        begin
            rgb_seen <= rgb_seen + 1;
            if (expected_rgb.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result expected none actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                o = expected_rgb.pop_front();
                if (m_axis_tdata[7:0] !== o.r)
                begin
                    errors++;
                    $display("%0t: red expected %0d actual %0d", $time, o.r, m_axis_tdata[7:0]);
                end
                if (m_axis_tdata[15:8] !== o.g)
                begin
                    errors++;
                    $display("%0t: green expected %0d actual %0d", $time, o.g,
                             m_axis_tdata[15:8]);
                end
                if (m_axis_tdata[23:16] !== o.b)
                begin
                    errors++;
                    $display("%0t: blue expected %0d actual %0d", $time, o.b,
                             m_axis_tdata[23:16]);
                end
                if (m_axis_tlast !== o.last)
                begin
                    errors++;
                    $display("%0t: run_last expected %b actual %b", $time, o.last,
                             m_axis_tlast);
                end
            end
        end
        // one long hold-off so the block backs up onto its input
        if (!hold_done && rgb_seen == 30)
        begin
            hold_done <= 1'b1;
            hold_cnt <= 300;
            m_axis_tready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end
        else if (out_gap > 0)
        begin
            out_gap <= out_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 4) == 0)
        begin
            out_gap <= $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= IDLE_LIMIT)
        begin
            $display("dft_bin_boost_yuyv_to_rgb verification failed");
            $finish;
        end
    end

    task automatic drain();
        wait (pending_pairs.size() == 0 && !s_axis_tvalid && expected_rgb.size() == 0);
        // a pair that gives no result may still be in work
        repeat (20) @(posedge clk);
    endtask

    task automatic write_gain(logic [10:0] g);
        @(posedge clk);
        bin_gain_we <= 1'b1;
        bin_gain_q8 <= g;
        @(posedge clk);
        bin_gain_we <= 1'b0;
        gain_now = g;
    endtask

    task automatic queue_random(int n);
        int len;
        while (n > 0)
        begin
            case ($urandom_range(0, 7))
                0: len = $urandom_range(1, 7);
                1: len = $urandom_range(17, 22);
                default: len = $urandom_range(8, 16);
            endcase
            queue_frame(len);
            // an occasional stray pair without a frame start
            if ($urandom_range(0, 5) == 0)
                pending_pairs.push_back(rand_pair(1'b0));
            n -= len;
        end
    endtask

    initial
    begin
        pair_t p;
        make_twiddles();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no frame start after reset: first pair is pair zero
        for (int i = 0; i < 8; i++)
        begin
            p.sof = 1'b0;
            p.y1 = (i % 2) ? 8'd255 : 8'd0;
            p.u = (i < 4) ? 8'd0 : 8'd255;
            p.y2 = (i % 2) ? 8'd0 : 8'd255;
            p.v = (i < 4) ? 8'd255 : 8'd0;
            pending_pairs.push_back(p);
        end
        // filtered pairs, then pairs past the saturated counter
        for (int i = 0; i < 10; i++)
            pending_pairs.push_back(rand_pair(1'b0));
        // frame cut short by a new frame start
        queue_frame(3);
        queue_frame(9);
        drain();

        write_gain(11'd0);
        queue_frame(9);
        queue_random(8);
        drain();

        write_gain(11'd2047);
        queue_frame(8);
        queue_random(12);
        drain();

        write_gain(11'($urandom_range(1, 2046)));
        queue_random(18);
        drain();

        quiet = 1'b1;
        write_gain(11'd768);
        queue_random(12);
        drain();

        repeat (50) @(posedge clk);
        if (errors == 0 && expected_rgb.size() == 0)
            $display("dft_bin_boost_yuyv_to_rgb verification clean");
        else
            $display("dft_bin_boost_yuyv_to_rgb verification failed");
        $finish;
    end

endmodule
